@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, quiet while in reset.
`define ATSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define ATSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/atss_pkg.sv @@
package atss_pkg;

  // Fixed field widths
  localparam int unsigned ARG_W   = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned TERMS_W = 9;
  localparam int unsigned TOL_W   = 25;
  localparam int unsigned PWR_W   = 25;   // Q24 power magnitude, <= 2^24
  localparam int unsigned SQ_W    = 31;   // Q30 x^2, <= 2^30
  localparam int unsigned PROD_W  = PWR_W + SQ_W;
  localparam int unsigned RND_SH  = 30;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);
  localparam int unsigned MAX_TERMS_DEF = 256;

  // Microprogram step addresses
  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_SQ     = 3'd1;
  localparam step_t S_DIVLD  = 3'd2;
  localparam step_t S_DIVRUN = 3'd3;
  localparam step_t S_ACC    = 3'd4;
  localparam step_t S_MUL    = 3'd5;
  localparam step_t S_RND    = 3'd6;
  localparam step_t S_DONE   = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD,    // capture argument magnitude and sign
    OP_SQ,      // x^2, first power, clear sum and index
    OP_DIVLD,   // load divider with power / (2k+1)
    OP_DIVRUN,  // one quotient bit
    OP_ACC,     // add term, record count and flag
    OP_MUL,     // power * x^2
    OP_RND,     // round to Q24, next index
    OP_DONE     // drive result word
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_DIV_BUSY,
    C_STOP
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic div_last;  // divider produces its final bit this cycle
    logic stop;      // term below tolerance or term limit reached
  } stat_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_START, target: S_IDLE};
      S_SQ:     w = '{op: OP_SQ,     cond: C_NEXT,     target: S_IDLE};
      S_DIVLD:  w = '{op: OP_DIVLD,  cond: C_NEXT,     target: S_IDLE};
      S_DIVRUN: w = '{op: OP_DIVRUN, cond: C_DIV_BUSY, target: S_DIVRUN};
      S_ACC:    w = '{op: OP_ACC,    cond: C_STOP,     target: S_DONE};
      S_MUL:    w = '{op: OP_MUL,    cond: C_NEXT,     target: S_IDLE};
      S_RND:    w = '{op: OP_RND,    cond: C_ALWAYS,   target: S_DIVLD};
      S_DONE:   w = '{op: OP_DONE,   cond: C_ALWAYS,   target: S_IDLE};
      default:  w = '{op: OP_LOAD,   cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/arctanh_series_sum_top.sv @@
// arctanh Maclaurin series: sum of x^(2k+1)/(2k+1) for a Q1.15 argument, Q8.24 result.
// Command word: argument_i is taken at a rising edge with start high and busy low.
// Result word: series_sum_o, terms_used_o and not_converged_o are valid for the one
//   cycle in which done_o is high; the receiver cannot hold them off.
// Tolerance: cfg_we_i / cfg_wdata_i write the stop threshold (Q24, reset value 17);
//   write it only while busy is low and no result is pending.
// Steps: each term loads the divider, runs the one-bit-per-cycle divider
//   by 2k+1 to its last quotient bit, accumulates, then multiplies by x^2
//   and rounds; the last term stops after accumulating. A word runs N
//   terms, with N from 1 to MAX_TERMS.
// busy drops in the cycle done_o is high, so a new command can be accepted
//   while the previous result is on the ports.
// Reset (rst_ni low, asynchronous) returns the step counter to idle, drops
//   done_o and restores the tolerance to 17; any word in flight is lost.
// Control: a short microprogram steps through the datapath, with a step
//   counter and conditional jumps on start, divider-done and the stop test.
module arctanh_series_sum_top #(
  parameter int unsigned MAX_TERMS = atss_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [atss_pkg::ARG_W-1:0] argument_i,
  input  logic                              cfg_we_i,
  input  logic [atss_pkg::TOL_W-1:0]        cfg_wdata_i,
  output logic                              done_o,
  output logic signed [atss_pkg::SUM_W-1:0] series_sum_o,
  output logic [atss_pkg::TERMS_W-1:0]      terms_used_o,
  output logic                              not_converged_o
);

  atss_pkg::ctrl_t ctrl;
  atss_pkg::stat_t stat;

  // sequencer: step counter + control store
  atss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  // datapath: magnitude/sign, power, divider, sum, result register
  atss_dp #(
    .MaxTerms (MAX_TERMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .argument_i      (argument_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .series_sum_o    (series_sum_o),
    .terms_used_o    (terms_used_o),
    .not_converged_o (not_converged_o),
    .done_o          (done_o)
  );

endmodule

@@ design/atss_div.sv @@
// Restoring divider, one quotient bit per cycle while run_i is high.
module atss_div #(
  parameter int unsigned DvdW = atss_pkg::PWR_W,
  parameter int unsigned DsrW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ld_i,
  input  logic            run_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic [DvdW-1:0] quotient_o,
  output logic            last_o
);

  localparam int unsigned CntW = (DvdW > 1) ? $clog2(DvdW) : 1;

  logic [DsrW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] dsr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DsrW:0]   shifted, diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[DvdW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = ~diff[DsrW];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (ld_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = '0;
    end else if (run_i) begin
      rem_d = ge ? diff[DsrW-1:0] : shifted[DsrW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (ld_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == CntW'(DvdW - 1));

endmodule

@@ design/atss_seq.sv @@
// Step counter and control store.
module atss_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  atss_pkg::stat_t stat_i,
  output atss_pkg::ctrl_t ctrl_o,
  output logic            busy
);

  atss_pkg::step_t  step_q, step_d;
  atss_pkg::uword_t uw;
  logic             take;

  assign uw = atss_pkg::ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      atss_pkg::C_NEXT:     take = 1'b0;
      atss_pkg::C_ALWAYS:   take = 1'b1;
      atss_pkg::C_NO_START: take = ~start;
      atss_pkg::C_DIV_BUSY: take = ~stat_i.div_last;
      atss_pkg::C_STOP:     take = stat_i.stop;
      default:              take = 1'b0;
    endcase
    step_d = take ? uw.target : step_q + atss_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= atss_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op = uw.op;
  assign busy      = (step_q != atss_pkg::S_IDLE);

endmodule

@@ design/atss_dp.sv @@
// Series datapath: power, x^2, sum, term index, tolerance, result word.
module atss_dp #(
  parameter int unsigned MaxTerms = atss_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  atss_pkg::ctrl_t                   ctrl_i,
  output atss_pkg::stat_t                   stat_o,
  input  logic signed [atss_pkg::ARG_W-1:0] argument_i,
  input  logic                              cfg_we_i,
  input  logic [atss_pkg::TOL_W-1:0]        cfg_wdata_i,
  output logic signed [atss_pkg::SUM_W-1:0] series_sum_o,
  output logic [atss_pkg::TERMS_W-1:0]      terms_used_o,
  output logic                              not_converged_o,
  output logic                              done_o
);

  localparam int unsigned KW     = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned CW     = $clog2(MaxTerms + 1);
  localparam int unsigned DsrW   = KW + 1;
  localparam int unsigned MAG_W  = atss_pkg::MAG_W;
  localparam int unsigned PWR_W  = atss_pkg::PWR_W;
  localparam int unsigned SQ_W   = atss_pkg::SQ_W;
  localparam int unsigned PROD_W = atss_pkg::PROD_W;
  localparam int unsigned SUM_W  = atss_pkg::SUM_W;
  localparam int unsigned TW     = atss_pkg::TERMS_W;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (atss_pkg::RND_SH - 1);

  logic [atss_pkg::TOL_W-1:0] tol_q;
  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;
  logic [SQ_W-1:0]    sq_q;
  logic [PWR_W-1:0]   pwr_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SUM_W-2:0]   sum_q;
  logic [KW-1:0]      k_q;
  logic [CW-1:0]      cnt_q;
  logic               flag_q;
  logic [SUM_W-1:0]   res_q;
  logic [TW-1:0]      terms_q;
  logic               nc_q;
  logic               done_q;

  logic [2*MAG_W-1:0] sq_full;
  logic [PROD_W-1:0]  prod_full, rnd;
  logic [SUM_W-1:0]   sum_ext;
  logic [PWR_W-1:0]   term;
  logic               term_small, last_term;
  logic [CW+TW-1:0]   cnt_ext;
  logic               div_last;

  atss_div #(
    .DvdW (PWR_W),
    .DsrW (DsrW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ctrl_i.op == atss_pkg::OP_DIVLD),
    .run_i      (ctrl_i.op == atss_pkg::OP_DIVRUN),
    .dividend_i (pwr_q),
    .divisor_i  ({k_q, 1'b1}),
    .quotient_o (term),
    .last_o     (div_last)
  );

  assign sq_full    = mag_q * mag_q;
  assign prod_full  = pwr_q * sq_q;
  assign rnd        = prod_q + RND_HALF;
  assign sum_ext    = {1'b0, sum_q} + SUM_W'(term);
  assign term_small = (term < tol_q);
  assign last_term  = (k_q == KW'(MaxTerms - 1));
  assign stat_o     = '{div_last: div_last, stop: term_small | last_term};
  assign cnt_ext    = {{TW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= atss_pkg::TOL_RESET;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      done_q <= (ctrl_i.op == atss_pkg::OP_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      atss_pkg::OP_LOAD: begin
        neg_q <= argument_i[atss_pkg::ARG_W-1];
        mag_q <= argument_i[atss_pkg::ARG_W-1] ? (MAG_W'(0) - MAG_W'(argument_i))
                                                : MAG_W'(argument_i);
      end
      atss_pkg::OP_SQ: begin
        sq_q  <= sq_full[SQ_W-1:0];
        pwr_q <= {mag_q, 9'b0};
        sum_q <= '0;
        k_q   <= '0;
      end
      atss_pkg::OP_ACC: begin
        // saturate the magnitude at 2^31 - 1
        sum_q  <= sum_ext[SUM_W-1] ? {(SUM_W-1){1'b1}} : sum_ext[SUM_W-2:0];
        cnt_q  <= CW'(k_q) + CW'(1);
        flag_q <= ~term_small;
      end
      atss_pkg::OP_MUL: begin
        prod_q <= prod_full;
      end
      atss_pkg::OP_RND: begin
        pwr_q <= rnd[atss_pkg::RND_SH +: PWR_W];
        k_q   <= k_q + KW'(1);
      end
      atss_pkg::OP_DONE: begin
        res_q   <= neg_q ? (SUM_W'(0) - {1'b0, sum_q}) : {1'b0, sum_q};
        terms_q <= cnt_ext[TW-1:0];
        nc_q    <= flag_q;
      end
      default: begin
      end
    endcase
  end

  assign series_sum_o    = res_q;
  assign terms_used_o    = terms_q;
  assign not_converged_o = nc_q;
  assign done_o          = done_q;

endmodule

@@ design/atss_chk.sv @@
`include "assert_macros.svh"

// Port-level checks on the command/result sequence.
module atss_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted command always starts work
  `ATSS_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accepted word did not raise busy")

  // busy only rises on an accepted command
  `ATSS_ASSERT(a_busy_rise, clk_i, rst_ni, $rose(busy) |-> $past(start), "busy rose without start")

  // finishing work always yields a result strobe
  `ATSS_ASSERT(a_fell_done, clk_i, rst_ni, $fell(busy) |-> done_o, "busy fell without a result")

  // a result only follows a finished command
  `ATSS_ASSERT(a_done_after, clk_i, rst_ni, done_o |-> (!busy && $past(busy)), "stray result strobe")

endmodule

bind arctanh_series_sum_top atss_chk u_atss_chk (.*);

@@ bench/arctanh_series_sum_top_tb.sv @@
module arctanh_series_sum_top_tb;

  localparam int unsigned ARG_W   = atss_pkg::ARG_W;
  localparam int unsigned SUM_W   = atss_pkg::SUM_W;
  localparam int unsigned TERMS_W = atss_pkg::TERMS_W;
  localparam int unsigned TOL_W   = atss_pkg::TOL_W;
  localparam logic [TOL_W-1:0] TOL_RESET = atss_pkg::TOL_RESET;

  // Term limit of the instance; the predictor uses the same figure.
  localparam int unsigned TERM_LIMIT = atss_pkg::MAX_TERMS_DEF;

  // Sized for the slowest word, at the full term limit.
  // About 140 words, each with its longest driver gap, taken ~5x over.
  localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

  // Expected result word. tail is the magnitude of the last term added;
  // it is not a port, just used to build the last-term-small case.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [TERMS_W-1:0] terms;
    logic               nc;
    logic [63:0]        tail;
  } series_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [ARG_W-1:0]  argument_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [TOL_W-1:0]         cfg_wdata_i = '0;
  logic                     done_o;
  logic signed [SUM_W-1:0]  series_sum_o;
  logic [TERMS_W-1:0]       terms_used_o;
  logic                     not_converged_o;

  logic signed [ARG_W-1:0]  args_pending[$];   // command words not yet driven
  series_word_t             sums_expected[$];  // one per accepted command word
  series_word_t             want;
  logic [TOL_W-1:0]         tol_shadow = TOL_RESET;  // tracks the tolerance register
  bit                       gap_free = 1'b0;   // suppresses driver gaps for a phase
  int                       gap_left = 0;
  int                       mismatches = 0;
  longint unsigned          cycles = 0;

  arctanh_series_sum_top #(
    .MAX_TERMS(TERM_LIMIT)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .argument_i     (argument_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .series_sum_o   (series_sum_o),
    .terms_used_o   (terms_used_o),
    .not_converged_o(not_converged_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Series predictor. Works on |x|: power is Q24, x^2 is Q30, each term is
  // the power truncated by 2k+1, the sum saturates at 2^31-1 and takes the
  // sign of x at the end. Stops after the first term below tolerance or at the term limit.
  function automatic series_word_t arctanh_estimate(input logic signed [ARG_W-1:0] arg,
                                                    input logic [TOL_W-1:0] tol);
    series_word_t     r;
    logic [63:0]      mag;
    logic [63:0]      sq;
    logic [63:0]      pwr;
    logic [63:0]      term;
    logic [63:0]      acc;
    logic             hit;
    int unsigned      k;
    mag = arg[ARG_W-1] ? 64'h10000 - {48'd0, arg} : {48'd0, arg};
    sq = mag * mag;
    pwr = mag << 9;
    acc = '0;
    hit = 1'b0;
    r = '0;
    for (k = 0; k < TERM_LIMIT && !hit; k++) begin
      term = pwr / (64'(k) * 2 + 1);
      acc = acc + term;
      if (acc > 64'h7FFF_FFFF) begin
        acc = 64'h7FFF_FFFF;
      end
      r.terms = TERMS_W'(k + 1);
      r.tail = term;
      if (term < {39'd0, tol}) begin
        hit = 1'b1;
      end else begin
        pwr = (pwr * sq + (64'd1 << 29)) >> 30;
      end
    end
    r.nc = !hit;
    r.sum = arg[ARG_W-1] ? SUM_W'(64'd0 - acc) : SUM_W'(acc);
    return r;
  endfunction

  task automatic note_error(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // Wait until every queued word has been sent and every result has come.
  task automatic drain();
    while (args_pending.size() != 0 || start || sums_expected.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Tolerance writes only with the block idle; the shadow follows the write.
  task automatic set_tolerance(input logic [TOL_W-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    tol_shadow = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    repeat (n) args_pending.push_back(ARG_W'($urandom));
  endtask

  // Random tolerance spread over small, mid and large magnitudes.
  function automatic logic [TOL_W-1:0] random_tolerance();
    case ($urandom_range(2))
      0: return TOL_W'($urandom_range(255, 1));
      1: return TOL_W'($urandom_range(65535, 256));
      default: return TOL_W'($urandom_range(16777216, 65536));
    endcase
  endfunction

  // Driver. start stays high until the word is taken (start && !busy). A
  // word may be presented while busy, so it goes in the cycle done_o is up.
  // Random gaps, each begun with a 5% chance unless gap_free is set, keep start low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sums_expected.push_back(arctanh_estimate(argument_i, tol_shadow));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (!gap_free && $urandom_range(99) < 5) begin
          gap_left <= $urandom_range(9, 1);
          start <= 1'b0;
        end else if (args_pending.size() != 0) begin
          start <= 1'b1;
          argument_i <= args_pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. The result word is up for one cycle only; compare each field
  // against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sums_expected.size() == 0) begin
        note_error($sformatf("unexpected word sum=%0d terms=%0d nc=%0b",
                             series_sum_o, terms_used_o, not_converged_o));
      end else begin
        want = sums_expected.pop_front();
        if (series_sum_o !== want.sum || terms_used_o !== want.terms ||
            not_converged_o !== want.nc) begin
          note_error($sformatf("sum %0d/%0d terms %0d/%0d nc %0b/%0b (exp/act)",
                               $signed(want.sum), series_sum_o, want.terms,
                               terms_used_o, want.nc, not_converged_o));
        end
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("arctanh_series_sum_top: mismatch");
      $finish;
    end
  end

  initial begin
    series_word_t probe;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset tolerance (17): zero, smallest steps, both ends of the range.
    args_pending.push_back(16'sh0000);   // zero argument, one term
    args_pending.push_back(16'sh0001);
    args_pending.push_back(16'shFFFF);
    args_pending.push_back(16'sh7FFF);   // nearly 1, runs to the limit
    args_pending.push_back(16'sh8000);   // x = -1, diverges
    args_pending.push_back(16'sh4000);
    args_pending.push_back(16'shC000);
    args_pending.push_back(16'sh5555);
    args_pending.push_back(16'shAAAA);
    args_pending.push_back(16'sh0100);
    args_pending.push_back(16'shFFFE);
    queue_random(25);

    // Zero tolerance: every word runs the full term count, so keep it short.
    set_tolerance('0);
    args_pending.push_back(16'sh0000);
    args_pending.push_back(16'sh0001);
    args_pending.push_back(16'sh8000);
    queue_random(2);

    // Largest tolerance, and a stretch with the driver never idling.
    set_tolerance(TOL_W'(16777216));
    gap_free = 1'b1;
    args_pending.push_back(16'sh8000);
    args_pending.push_back(16'sh7FFF);
    args_pending.push_back(16'sh0000);
    args_pending.push_back(16'sh0001);
    queue_random(22);
    drain();
    gap_free = 1'b0;

    // Last term small: tolerance just above the final term of a 32700
    // argument, so the limit is reached but the word still converges.
    probe = arctanh_estimate(16'sd32700, '0);
    set_tolerance(TOL_W'(probe.tail + 1));
    args_pending.push_back(16'sd32700);
    args_pending.push_back(-16'sd32700);
    queue_random(8);

    // A few random tolerance settings.
    repeat (3) begin
      set_tolerance(random_tolerance());
      queue_random(21);
    end

    drain();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && sums_expected.size() == 0) begin
      $display("arctanh_series_sum_top: match");
    end else begin
      $display("arctanh_series_sum_top: mismatch");
    end
    $finish;
  end

endmodule
